/* rtl/ata_pio_lba28_sector_reader_top_assert.svh */
// Assertion macros for the ATA PIO sector reader checker.
`ifndef ATA_PIO_LBA28_SECTOR_READER_TOP_ASSERT_SVH
`define ATA_PIO_LBA28_SECTOR_READER_TOP_ASSERT_SVH

// Same-cycle implication.
`define ATAPIO_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("atapio check failed");

// Next-cycle implication.
`define ATAPIO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("atapio check failed");

`endif

/* rtl/atapio_pkg.sv */
// ----------------------------------------------------------------------------
// atapio_pkg
// Types and constants of the ATA PIO LBA28 sector reader.
// ----------------------------------------------------------------------------
package atapio_pkg;

	localparam int RES_MAX   = 7;
	localparam int RES_CNT_W = 3;
	localparam int MAX_SECTORS = 255;

	// input item kinds
	localparam logic [1:0] IK_START  = 2'd0;
	localparam logic [1:0] IK_STATUS = 2'd1;
	localparam logic [1:0] IK_DATA   = 2'd2;
	localparam logic [1:0] IK_TICK   = 2'd3;

	// result kinds
	localparam logic [1:0] RK_WRITE  = 2'd0;
	localparam logic [1:0] RK_READ   = 2'd1;
	localparam logic [1:0] RK_WORD   = 2'd2;
	localparam logic [1:0] RK_FINISH = 2'd3;

	// configuration register indexes
	localparam logic [2:0] CFG_CAP0    = 3'd0;
	localparam logic [2:0] CFG_CAP1    = 3'd1;
	localparam logic [2:0] CFG_CAP2    = 3'd2;
	localparam logic [2:0] CFG_CAP3    = 3'd3;
	localparam logic [2:0] CFG_LBA48   = 3'd4;
	localparam logic [2:0] CFG_SPINUP  = 3'd5;
	localparam logic [2:0] CFG_SECTOR  = 3'd6;

	localparam logic [15:0] SPINUP_RESET = 16'd30000;
	localparam logic [15:0] SECTOR_RESET = 16'd2000;

	// task file
	localparam logic [9:0] BASE_PRIMARY   = 10'h1F0;
	localparam logic [9:0] BASE_SECONDARY = 10'h170;
	localparam logic [9:0] OFS_DATA     = 10'd0;
	localparam logic [9:0] OFS_SECCOUNT = 10'd2;
	localparam logic [9:0] OFS_LBA_LO   = 10'd3;
	localparam logic [9:0] OFS_LBA_MID  = 10'd4;
	localparam logic [9:0] OFS_LBA_HI   = 10'd5;
	localparam logic [9:0] OFS_DRV_HEAD = 10'd6;
	localparam logic [9:0] OFS_CMD_STAT = 10'd7;

	localparam logic [7:0] DRV_HEAD_BASE = 8'hE0;
	localparam logic [7:0] CMD_READ      = 8'h20;
	localparam logic [7:0] ST_BSY        = 8'h80;
	localparam logic [7:0] ST_DRQ        = 8'h08;
	localparam logic [7:0] ST_ERR_DF     = 8'h21;

	localparam logic [32:0] LBA28_LIMIT = 33'd268435455;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'b0001,
		PH_SPINUP  = 4'b0010,
		PH_DATA    = 4'b0100,
		PH_BETWEEN = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  port;
		logic [7:0]  wbyte;
		logic [15:0] word;
		logic [15:0] pos;
		logic        fail;
	} res_t;

	function automatic res_t mk_res(input logic [1:0] kind, input logic [9:0] port,
			input logic [7:0] wbyte, input logic [15:0] word, input logic [15:0] pos,
			input logic fail);
		res_t r;
		r.kind  = kind;
		r.port  = port;
		r.wbyte = wbyte;
		r.word  = word;
		r.pos   = pos;
		r.fail  = fail;
		return r;
	endfunction

endpackage

/* rtl/ata_pio_lba28_sector_reader_top.sv */
// ----------------------------------------------------------------------------
// ata_pio_lba28_sector_reader_top
// Host-side ATA PIO LBA28 read engine: checks a start request, issues the
// task file writes and READ SECTORS, polls status and moves data words.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  in      | input     | in_valid / in_ready  | kind, drive_number, first_sector,
//          |           |                      | requested_count, bus_read_value
//  out     | output    | out_valid / out_ready| result_kind, port_address, write_byte,
//          |           |                      | word_out, word_position, failed,
//          |           |                      | last_of_run
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// An item is held in the input register, then its results go into a
// 7-deep output shift buffer and leave one per cycle while out_ready is high.
// Results per item: one per polled status or timeout tick, two per data word,
// seven per started read (one if rejected), none otherwise. The output port sets the rate.
// A new item loads while the last result of the previous one is taken.
// Reset is asynchronous; no clearing pass. cfg_ready is always high.

module ata_pio_lba28_sector_reader_top
	import atapio_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [1:0]  drive_number,
	input  logic [31:0] first_sector,
	input  logic [15:0] requested_count,
	input  logic [15:0] bus_read_value,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  result_kind,
	output logic [9:0]  port_address,
	output logic [7:0]  write_byte,
	output logic [15:0] word_out,
	output logic [15:0] word_position,
	output logic        failed,
	output logic        last_of_run,

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// configuration
	logic [31:0] cap_q [4];
	logic [3:0]  lba48_q;
	logic [15:0] spinup_q;
	logic [15:0] sector_to_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) cap_q[i] <= '0;
			lba48_q     <= '0;
			spinup_q    <= SPINUP_RESET;
			sector_to_q <= SECTOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CAP0:   cap_q[0]    <= cfg_data;
				CFG_CAP1:   cap_q[1]    <= cfg_data;
				CFG_CAP2:   cap_q[2]    <= cfg_data;
				CFG_CAP3:   cap_q[3]    <= cfg_data;
				CFG_LBA48:  lba48_q     <= cfg_data[3:0];
				CFG_SPINUP: spinup_q    <= cfg_data[15:0];
				CFG_SECTOR: sector_to_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// input register
	logic        valid_s1;
	logic [1:0]  kind_s1;
	logic [1:0]  drive_s1;
	logic [31:0] lba_s1;
	logic [15:0] count_s1;
	logic [15:0] value_s1;

	// output shift buffer
	res_t                 res_q [RES_MAX];
	logic [RES_CNT_W-1:0] cnt_q;

	logic out_take, buf_free, advance;

	assign out_take = out_valid && out_ready;
	assign buf_free = (cnt_q == '0) || ((cnt_q == RES_CNT_W'(1)) && out_take);
	assign advance  = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1  <= kind;
			drive_s1 <= drive_number;
			lba_s1   <= first_sector;
			count_s1 <= requested_count;
			value_s1 <= bus_read_value;
		end
	end

	// engine state
	phase_t      phase_q, phase_d;
	logic [1:0]  drive_q, drive_d;
	logic [7:0]  total_q, total_d;
	logic [7:0]  sect_q, sect_d;
	logic [7:0]  word_q, word_d;
	logic [15:0] ticks_q, ticks_d;

	res_t                 res_d [RES_MAX];
	logic [RES_CNT_W-1:0] num_d;

	logic [9:0]  base_act, base_new;
	logic [32:0] end_sum;
	logic [31:0] cap_sel;
	logic        bad;
	logic [7:0]  st;
	logic [7:0]  drv_head;

	always_comb begin
		phase_d = phase_q;
		drive_d = drive_q;
		total_d = total_q;
		sect_d  = sect_q;
		word_d  = word_q;
		ticks_d = ticks_q;
		num_d   = '0;
		for (int i = 0; i < RES_MAX; i++) res_d[i] = '0;

		base_act = drive_q[1] ? BASE_SECONDARY : BASE_PRIMARY;
		base_new = drive_s1[1] ? BASE_SECONDARY : BASE_PRIMARY;
		end_sum  = {1'b0, lba_s1} + {17'b0, count_s1};
		cap_sel  = cap_q[drive_s1];
		bad      = (count_s1 == '0) || (count_s1 > 16'(MAX_SECTORS))
			|| (end_sum > {1'b0, cap_sel})
			|| (lba48_q[drive_s1] && (end_sum >= LBA28_LIMIT));
		st       = value_s1[7:0];
		drv_head = DRV_HEAD_BASE | {3'b000, drive_s1[0], lba_s1[27:24]};

		case (kind_s1)
			IK_START: begin
				if (phase_q == PH_IDLE) begin
					if (bad) begin
						res_d[0] = mk_res(RK_FINISH, '0, '0, '0, '0, 1'b1);
						num_d    = RES_CNT_W'(1);
					end else begin
						res_d[0] = mk_res(RK_WRITE, base_new + OFS_DRV_HEAD, drv_head,
							'0, '0, 1'b0);
						res_d[1] = mk_res(RK_WRITE, base_new + OFS_SECCOUNT, count_s1[7:0],
							'0, '0, 1'b0);
						res_d[2] = mk_res(RK_WRITE, base_new + OFS_LBA_LO, lba_s1[7:0],
							'0, '0, 1'b0);
						res_d[3] = mk_res(RK_WRITE, base_new + OFS_LBA_MID, lba_s1[15:8],
							'0, '0, 1'b0);
						res_d[4] = mk_res(RK_WRITE, base_new + OFS_LBA_HI, lba_s1[23:16],
							'0, '0, 1'b0);
						res_d[5] = mk_res(RK_WRITE, base_new + OFS_CMD_STAT, CMD_READ,
							'0, '0, 1'b0);
						res_d[6] = mk_res(RK_READ, base_new + OFS_CMD_STAT, '0,
							'0, '0, 1'b0);
						num_d    = RES_CNT_W'(RES_MAX);
						drive_d  = drive_s1;
						total_d  = count_s1[7:0];
						sect_d   = '0;
						word_d   = '0;
						ticks_d  = spinup_q;
						phase_d  = PH_SPINUP;
					end
				end
			end
			IK_STATUS: begin
				if (phase_q == PH_SPINUP) begin
					num_d = RES_CNT_W'(1);
					if (((st & ST_BSY) == '0) && ((st & ST_DRQ) != '0)) begin
						phase_d  = PH_DATA;
						word_d   = '0;
						res_d[0] = mk_res(RK_READ, base_act + OFS_DATA, '0, '0, '0, 1'b0);
					end else begin
						res_d[0] = mk_res(RK_READ, base_act + OFS_CMD_STAT, '0, '0, '0,
							1'b0);
					end
				end else if (phase_q == PH_BETWEEN) begin
					num_d = RES_CNT_W'(1);
					if ((st & ST_BSY) != '0) begin
						res_d[0] = mk_res(RK_READ, base_act + OFS_CMD_STAT, '0, '0, '0,
							1'b0);
					end else if ((st & ST_ERR_DF) != '0) begin
						phase_d  = PH_IDLE;
						res_d[0] = mk_res(RK_FINISH, '0, '0, '0, '0, 1'b1);
					end else begin
						phase_d  = PH_DATA;
						word_d   = '0;
						res_d[0] = mk_res(RK_READ, base_act + OFS_DATA, '0, '0, '0, 1'b0);
					end
				end
			end
			IK_DATA: begin
				if (phase_q == PH_DATA) begin
					num_d    = RES_CNT_W'(2);
					res_d[0] = mk_res(RK_WORD, '0, '0, value_s1, {sect_q, word_q}, 1'b0);
					if (word_q != 8'hFF) begin
						word_d   = word_q + 8'd1;
						res_d[1] = mk_res(RK_READ, base_act + OFS_DATA, '0, '0, '0, 1'b0);
					end else if (({1'b0, sect_q} + 9'd1) >= {1'b0, total_q}) begin
						// last word of the last sector
						phase_d  = PH_IDLE;
						word_d   = '0;
						res_d[1] = mk_res(RK_FINISH, '0, '0, '0, '0, 1'b0);
					end else begin
						sect_d   = sect_q + 8'd1;
						word_d   = '0;
						ticks_d  = sector_to_q;
						phase_d  = PH_BETWEEN;
						res_d[1] = mk_res(RK_READ, base_act + OFS_CMD_STAT, '0, '0, '0,
							1'b0);
					end
				end
			end
			IK_TICK: begin
				if ((phase_q == PH_SPINUP) || (phase_q == PH_BETWEEN)) begin
					if (ticks_q <= 16'd1) begin
						ticks_d  = '0;
						phase_d  = PH_IDLE;
						num_d    = RES_CNT_W'(1);
						res_d[0] = mk_res(RK_FINISH, '0, '0, '0, '0, 1'b1);
					end else begin
						ticks_d = ticks_q - 16'd1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			drive_q <= '0;
			total_q <= '0;
			sect_q  <= '0;
			word_q  <= '0;
			ticks_q <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			drive_q <= drive_d;
			total_q <= total_d;
			sect_q  <= sect_d;
			word_q  <= word_d;
			ticks_q <= ticks_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (advance) begin
			cnt_q <= num_d;
		end else if (out_take) begin
			cnt_q <= cnt_q - RES_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int i = 0; i < RES_MAX; i++) res_q[i] <= res_d[i];
		end else if (out_take) begin
			for (int i = 0; i < RES_MAX - 1; i++) res_q[i] <= res_q[i+1];
		end
	end

	assign out_valid     = (cnt_q != '0);
	assign result_kind   = res_q[0].kind;
	assign port_address  = res_q[0].port;
	assign write_byte    = res_q[0].wbyte;
	assign word_out      = res_q[0].word;
	assign word_position = res_q[0].pos;
	assign failed        = res_q[0].fail;
	assign last_of_run   = (cnt_q == RES_CNT_W'(1));

endmodule

/* rtl/atapio_checker.sv */
// ----------------------------------------------------------------------------
// atapio_checker
// Port-level checks of the ATA PIO sector reader, bound to the top level.
// ----------------------------------------------------------------------------
`include "ata_pio_lba28_sector_reader_top_assert.svh"

module atapio_checker
	import atapio_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  result_kind,
	input logic [9:0]  port_address,
	input logic [7:0]  write_byte,
	input logic [15:0] word_out,
	input logic [15:0] word_position,
	input logic        failed,
	input logic        last_of_run
);

	// a stalled result transaction holds
	`ATAPIO_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable({result_kind, port_address, write_byte, word_out,
		word_position, failed, last_of_run}))

	// a finish always closes the run of its item
	`ATAPIO_ASSERT_NOW(a_finish_last, clk, arst_n,
		out_valid && (result_kind == RK_FINISH), last_of_run)

	// a data word is always followed by a read request or a finish
	`ATAPIO_ASSERT_NOW(a_word_not_last, clk, arst_n,
		out_valid && (result_kind == RK_WORD), !last_of_run)

	// failure is only flagged on a finish
	`ATAPIO_ASSERT_NOW(a_fail_on_finish, clk, arst_n,
		out_valid && (result_kind != RK_FINISH), !failed)

endmodule

bind ata_pio_lba28_sector_reader_top atapio_checker u_atapio_checker (.*);
